[src/usb_port_reset_sequencer_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef USB_PORT_RESET_SEQUENCER_UNIT_MACROS_SVH
`define USB_PORT_RESET_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UPRS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uprs: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define UPRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uprs: next-cycle check failed");

`endif

[src/uprs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package uprs_pkg;

  // Opcodes of an input beat
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd0;
  localparam logic [1:0] CFG_POLL_TICKS = 2'd1;
  localparam logic [1:0] CFG_MAX_POLLS  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [9:0] HOLD_TICKS_RST = 10'd50;
  localparam logic [9:0] POLL_TICKS_RST = 10'd10;
  localparam logic [3:0] MAX_POLLS_RST  = 4'd10;

  // Port status and control bits
  localparam logic [31:0] ST_CONNECT        = 32'h0000_0001;
  localparam logic [31:0] ST_CONN_CHANGE    = 32'h0000_0002;
  localparam logic [31:0] ST_ENABLED        = 32'h0000_0004;
  localparam logic [31:0] ST_EN_CHANGE      = 32'h0000_0008;
  localparam logic [31:0] ST_OVERCUR_CHANGE = 32'h0000_0020;
  localparam logic [31:0] ST_RESET_BIT      = 32'h0000_0100;
  localparam logic [31:0] ST_CHANGE_MASK = ST_CONN_CHANGE | ST_EN_CHANGE | ST_OVERCUR_CHANGE;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HOLD = 3'b010,
    PH_POLL = 3'b100
  } phase_t;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  port_select;
    logic [31:0] port_status;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [3:0]  write_port;
    logic [31:0] write_data;
    logic        done_res;
    logic [31:0] final_status;
    logic        busy_res;
  } out_item_t;

  typedef struct packed {
    logic [9:0] hold_ticks;
    logic [9:0] poll_ticks;
    logic [3:0] max_polls;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [9:0] tick_timer;
    logic [3:0] poll_count;
    logic [3:0] active_port;
  } seq_state_t;

  // A zero interval counts as one tick
  function automatic logic [9:0] interval(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

`default_nettype wire

[src/uprs_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module uprs_step (
  input  uprs_pkg::seq_state_t cur,
  input  uprs_pkg::cfg_t       cfg,
  input  uprs_pkg::in_item_t   item,
  output uprs_pkg::seq_state_t nxt,
  output uprs_pkg::out_item_t  result
);
  import uprs_pkg::*;

  logic        wv;
  logic        done;
  logic [31:0] wdata;
  logic [3:0]  limit;
  logic [3:0]  count_inc;
  logic        poll_stop;
  logic        poll_write;

  assign limit     = (cfg.max_polls == 4'd0) ? 4'd1 : cfg.max_polls;
  assign count_inc = cur.poll_count + 4'd1;

  // Decide the outcome of one poll from the sampled status
  always_comb begin
    poll_stop  = 1'b0;
    poll_write = 1'b0;
    priority if ((item.port_status & ST_CONNECT) == 32'd0) begin
      poll_stop = 1'b1;
    end else if ((item.port_status & (ST_EN_CHANGE | ST_CONN_CHANGE)) != 32'd0) begin
      poll_write = 1'b1;
    end else if ((item.port_status & ST_ENABLED) != 32'd0) begin
      poll_stop = 1'b1;
    end else begin
      // connected and quiet: keep polling
      poll_stop = 1'b0;
    end
    if (count_inc >= limit) begin
      poll_stop = 1'b1;
    end
  end

  // Advance the sequence by one beat
  always_comb begin
    nxt   = cur;
    wv    = 1'b0;
    done  = 1'b0;
    wdata = 32'd0;
    if (item.opcode == OP_START) begin
      nxt.active_port = item.port_select;
      nxt.phase       = PH_HOLD;
      nxt.tick_timer  = interval(cfg.hold_ticks);
      nxt.poll_count  = 4'd0;
      wv              = 1'b1;
      wdata           = (item.port_status | ST_RESET_BIT) & ~ST_CHANGE_MASK;
    end else begin
      unique case (cur.phase)
        PH_HOLD: begin
          if (cur.tick_timer <= 10'd1) begin
            wv             = 1'b1;
            wdata          = item.port_status & ~(ST_CHANGE_MASK | ST_RESET_BIT);
            nxt.phase      = PH_POLL;
            nxt.tick_timer = interval(cfg.poll_ticks);
            nxt.poll_count = 4'd0;
          end else begin
            nxt.tick_timer = cur.tick_timer - 10'd1;
          end
        end
        PH_POLL: begin
          if (cur.tick_timer <= 10'd1) begin
            nxt.poll_count = count_inc;
            wv             = poll_write;
            wdata          = poll_write ?
                             ((item.port_status & ~ST_CHANGE_MASK) |
                              ST_EN_CHANGE | ST_CONN_CHANGE) : 32'd0;
            done           = poll_stop;
            if (poll_stop) begin
              nxt.phase      = PH_IDLE;
              nxt.tick_timer = 10'd0;
            end else begin
              nxt.tick_timer = interval(cfg.poll_ticks);
            end
          end else begin
            nxt.tick_timer = cur.tick_timer - 10'd1;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  // Zero the fields that carry no meaning on this beat
  always_comb begin
    result.write_valid  = wv;
    result.write_port   = wv ? nxt.active_port : 4'd0;
    result.write_data   = wdata;
    result.done_res     = done;
    result.final_status = done ? item.port_status : 32'd0;
    result.busy_res     = (nxt.phase == PH_HOLD) || (nxt.phase == PH_POLL);
  end

endmodule

`default_nettype wire

[src/usb_port_reset_sequencer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Root port reset sequencer.
// Input channel (in_valid/in_ready/in_data): each beat is either a start,
// which latches port_select and issues the reset-set write, or a timer tick,
// which counts down the hold time, issues the reset-release write and then
// polls the sampled port_status once per poll interval.
// Output channel (out_valid/out_ready/out_data): exactly one result beat per
// input beat, carrying the optional port register write, done with the final
// status, and the busy flag.
// The result of an accepted beat is registered and shown in the next cycle.
// Throughput is one beat per cycle unless the receiver stalls; the single pass
// of next-state logic sits between the state registers and the output register.
// When the receiver stalls, the output register holds its beat and in_ready
// drops only while that beat is still waiting, so the input is taken again
// in the same cycle the output drains.
// Reset puts the sequencer idle, empties the output register and loads the
// default hold time, poll interval and poll limit. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once; index 3 is ignored.

module usb_port_reset_sequencer_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  uprs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output uprs_pkg::out_item_t out_data,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [9:0]          cfg_data
);
  import uprs_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  out_item_t  result;
  logic       in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks <= HOLD_TICKS_RST;
      cfg.poll_ticks <= POLL_TICKS_RST;
      cfg.max_polls  <= MAX_POLLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_TICKS: cfg.hold_ticks <= cfg_data;
        CFG_POLL_TICKS: cfg.poll_ticks <= cfg_data;
        CFG_MAX_POLLS:  cfg.max_polls  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  uprs_step u_step (
    .cur    (state),
    .cfg    (cfg),
    .item   (in_data),
    .nxt    (state_next),
    .result (result)
  );

  // Advance the sequence on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.tick_timer  <= 10'd0;
      state.poll_count  <= 4'd0;
      state.active_port <= 4'd0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[src/uprs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "usb_port_reset_sequencer_unit_macros.svh"

module uprs_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input uprs_pkg::in_item_t  in_data,
  input wire                 out_valid,
  input wire                 out_ready,
  input uprs_pkg::out_item_t out_data
);
  import uprs_pkg::*;

  logic start_fire;

  assign start_fire = in_valid && in_ready && (in_data.opcode == OP_START);

  // A stalled result beat stays put
  `UPRS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // A finishing beat never reports busy
  `UPRS_ASSERT_SAME(a_done_not_busy, clk, rst, out_valid && out_data.done_res, !out_data.busy_res)

  // No write means zero write fields
  `UPRS_ASSERT_SAME(a_idle_write, clk, rst, out_valid && !out_data.write_valid,
                    out_data.write_port == 4'd0 && out_data.write_data == 32'd0)

  // A start yields the reset-set write for the new port next cycle
  `UPRS_ASSERT_NEXT(a_start_write, clk, rst, start_fire,
                    out_valid && out_data.write_valid && out_data.busy_res &&
                    (out_data.write_data & ST_RESET_BIT) != 32'd0 &&
                    (out_data.write_data & ST_CHANGE_MASK) == 32'd0 &&
                    out_data.write_port == $past(in_data.port_select))

endmodule

bind usb_port_reset_sequencer_unit uprs_checker u_uprs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
